/* rtl/tkss_pkg.sv */
// tkss_pkg: shared constants and types of the survivor selection block
// no dependencies

package tkss_pkg;

  localparam int unsigned CostW      = 48;
  localparam int unsigned CfgW       = 32;
  localparam int unsigned KeepCntW   = 8;
  localparam int unsigned SizeW      = 15;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned KeepMaxDef = 128;
  localparam int unsigned AgentDef   = 512;
  localparam int unsigned KeepRst    = 100;

  // -1000000 in q31.16
  localparam logic signed [CostW-1:0] EmptyCost = 48'shFFF0_BDC0_0000;
  localparam logic signed [CostW-1:0] CostMin   = 48'sh8000_0000_0000;

  localparam logic [CfgIdxW-1:0] RegWeight = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeep   = 1'b1;

  typedef struct packed {
    logic                    clr;
    logic                    ins;
    logic signed [CostW-1:0] cost;
  } cell_ctrl_t;

endpackage

/* rtl/tkss_cost.sv */
// tkss_cost: three stage pipeline for score minus weighted squared size
// depends on tkss_pkg

module tkss_cost (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [tkss_pkg::CostW-1:0] score_i,
  input  logic [tkss_pkg::SizeW-1:0]       node_count_i,
  input  logic [tkss_pkg::SizeW-1:0]       weight_count_i,
  input  logic [tkss_pkg::CfgW-1:0]        weight_i,
  output logic signed [tkss_pkg::CostW-1:0] cost_o,
  output logic                             done_o
);
  import tkss_pkg::*;

  logic [2:0]              vld_q;
  logic [SizeW:0]          params;
  logic [2*SizeW+1:0]      square_q;
  logic signed [CostW-1:0] score1_q, score2_q;
  logic [63:0]             prod_q;
  logic signed [CostW+1:0] diff;
  logic                    sat;
  logic signed [CostW-1:0] cost_q;

  assign params = {1'b0, node_count_i} + {1'b0, weight_count_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      square_q <= params * params;
      score1_q <= score_i;
    end
    if (vld_q[0]) begin
      prod_q   <= {32'b0, square_q} * {32'b0, weight_i};
      score2_q <= score1_q;
    end
    if (vld_q[1]) begin
      cost_q <= sat ? CostMin : diff[CostW-1:0];
    end
  end

  assign diff = {{2{score2_q[CostW-1]}}, score2_q} - $signed({2'b00, prod_q[63:16]});
  assign sat  = diff[CostW+1] & ~(diff[CostW] & diff[CostW-1]);

  assign cost_o = cost_q;
  assign done_o = vld_q[2];

endmodule

/* rtl/tkss_cell.sv */
// tkss_cell: one slot of the sorted survivor chain
// depends on tkss_pkg

module tkss_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 7,
  parameter int unsigned AGT_W = 9
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tkss_pkg::cell_ctrl_t              ctrl_i,
  input  logic [IDX_W-1:0]                  tail_i,
  input  logic [AGT_W-1:0]                  agent_i,
  input  logic signed [tkss_pkg::CostW-1:0] prev_cost_i,
  input  logic [AGT_W-1:0]                  prev_agent_i,
  input  logic                              prev_used_i,
  input  logic                              hit_prev_i,
  output logic signed [tkss_pkg::CostW-1:0] cost_o,
  output logic [AGT_W-1:0]                  agent_o,
  output logic                              used_o,
  output logic                              hit_o
);
  import tkss_pkg::*;

  logic signed [CostW-1:0] cost_q;
  logic [AGT_W-1:0]        agent_q;
  logic                    used_q;
  logic                    active, take, shift;

  assign active = IDX_W'(IDX) <= tail_i;
  assign hit_o  = active & (ctrl_i.cost >= cost_q);
  assign take   = ctrl_i.ins & hit_o & ~hit_prev_i;
  assign shift  = ctrl_i.ins & active & hit_prev_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= EmptyCost;
      used_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      cost_q <= EmptyCost;
      used_q <= 1'b0;
    end else if (take) begin
      cost_q <= ctrl_i.cost;
      used_q <= 1'b1;
    end else if (shift) begin
      cost_q <= prev_cost_i;
      used_q <= prev_used_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      agent_q <= agent_i;
    end else if (shift) begin
      agent_q <= prev_agent_i;
    end
  end

  assign cost_o  = cost_q;
  assign agent_o = agent_q;
  assign used_o  = used_q;

endmodule

/* rtl/top_k_survivor_select.sv */
// top_k_survivor_select: top level, request sequencer and survivor chain
// depends on tkss_pkg, tkss_cost, tkss_cell

// Keeps the best keep_count candidates of a round (keep_count clamped to
// 1..KEEP_MAX), sorted by cost (score minus size_cost_weight times squared
// parameter count), in a chain of KEEP_MAX cells that compare against the
// candidate in parallel and shift by one toward the tail. A request passes
// in order through acceptance (which also squares the parameter count),
// the weight multiply, the subtract with low saturation, a hand-off of the
// cost to the insertion step and the insertion into the chain. A result
// still waiting in the output register stalls the insertion step, and the
// next request is not accepted until that insertion is done.

module top_k_survivor_select #(
  parameter int unsigned KEEP_MAX    = tkss_pkg::KeepMaxDef,
  parameter int unsigned AGENT_SLOTS = tkss_pkg::AgentDef,
  localparam int unsigned IDX_W = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1,
  localparam int unsigned AGT_W = $clog2(AGENT_SLOTS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tkss_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tkss_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              first_of_round_i,
  input  logic [AGT_W-1:0]                  agent_index_i,
  input  logic signed [tkss_pkg::CostW-1:0] score_i,
  input  logic [tkss_pkg::SizeW-1:0]        node_count_i,
  input  logic [tkss_pkg::SizeW-1:0]        weight_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [AGT_W-1:0]                  evicted_index_o,
  output logic                              evicted_self_o
);
  import tkss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_COST = 3'b010,
    S_INS  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0]     weight_q;
  logic [KeepCntW-1:0] keep_q;
  logic [10:0]         keep_ext, tail_full;
  logic [IDX_W-1:0]    tail;

  logic                    accept, cost_done, ins, placed;
  logic signed [CostW-1:0] cand_cost;
  logic [AGT_W-1:0]        agent_q;
  cell_ctrl_t              ctrl;

  logic signed [CostW-1:0] cost_arr  [KEEP_MAX];
  logic [AGT_W-1:0]        agent_arr [KEEP_MAX];
  logic [KEEP_MAX-1:0]     used_vec, hit_vec, hit_prev;

  logic             out_valid_q, out_valid_d;
  logic [AGT_W-1:0] ev_index_q;
  logic             ev_self_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
      keep_q   <= KeepCntW'(KeepRst);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWeight: weight_q <= cfg_data_i;
        RegKeep:   keep_q   <= cfg_data_i[KeepCntW-1:0];
        default:   ;
      endcase
    end
  end

  assign keep_ext = 11'(keep_q);
  always_comb begin
    if (keep_ext == 11'd0) begin
      tail_full = 11'd0;
    end else if (keep_ext > 11'(KEEP_MAX)) begin
      tail_full = 11'(KEEP_MAX - 1);
    end else begin
      tail_full = keep_ext - 11'd1;
    end
  end
  assign tail = tail_full[IDX_W-1:0];

  // sequencer
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign ins        = (state_q == S_INS) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept)    state_d = S_COST;
      S_COST:  if (cost_done) state_d = S_INS;
      S_INS:   if (ins)       state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      agent_q <= agent_index_i;
    end
  end

  tkss_cost u_cost (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (accept),
    .score_i        (score_i),
    .node_count_i   (node_count_i),
    .weight_count_i (weight_count_i),
    .weight_i       (weight_q),
    .cost_o         (cand_cost),
    .done_o         (cost_done)
  );

  // survivor chain
  assign ctrl.clr  = accept & first_of_round_i;
  assign ctrl.ins  = ins;
  assign ctrl.cost = cand_cost;

  for (genvar j = 0; j < KEEP_MAX; j++) begin : g_cell
    logic signed [CostW-1:0] prev_cost;
    logic [AGT_W-1:0]        prev_agent;
    logic                    prev_used;

    if (j == 0) begin : g_head
      assign prev_cost   = EmptyCost;
      assign prev_agent  = '0;
      assign prev_used   = 1'b0;
      assign hit_prev[j] = 1'b0;
    end else begin : g_body
      assign prev_cost   = cost_arr[j-1];
      assign prev_agent  = agent_arr[j-1];
      assign prev_used   = used_vec[j-1];
      assign hit_prev[j] = hit_vec[j-1];
    end

    tkss_cell #(
      .IDX   (j),
      .IDX_W (IDX_W),
      .AGT_W (AGT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .tail_i       (tail),
      .agent_i      (agent_q),
      .prev_cost_i  (prev_cost),
      .prev_agent_i (prev_agent),
      .prev_used_i  (prev_used),
      .hit_prev_i   (hit_prev[j]),
      .cost_o       (cost_arr[j]),
      .agent_o      (agent_arr[j]),
      .used_o       (used_vec[j]),
      .hit_o        (hit_vec[j])
    );
  end

  assign placed = |hit_vec;

  // result register
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (ins & (~placed | used_vec[tail])) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins) begin
      ev_index_q <= placed ? agent_arr[tail] : agent_q;
      ev_self_q  <= ~placed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign evicted_index_o = ev_index_q;
  assign evicted_self_o  = ev_self_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cost_done |-> state_q == S_COST)
    else $error("cost result outside cost wait");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS |-> $onehot0(hit_vec & ~hit_prev))
    else $error("more than one insertion point in chain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clr |=> !used_vec[0])
    else $error("head slot not emptied at round start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins && out_valid_q |-> out_ready_i)
    else $error("pending result overwritten");

endmodule
